### rtl/bmhq_pkg.sv
// ============================================================================
// bmhq_pkg
// Shared types and constants of the binary max-heap priority queue.
// ============================================================================
`default_nettype none

package bmhq_pkg;

   // Field widths of the request and response transactions
   localparam int CMD_W     = 2;
   localparam int POS_W     = 6;
   localparam int VAL_W     = 32;
   localparam int CNT_OUT_W = 7;
   localparam int ERR_W     = 2;

   // Default number of heap slots
   localparam int CAPACITY_DEFAULT = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_EXTRACT = 2'd1,
      CMD_CHANGE  = 2'd2,
      CMD_REMOVE  = 2'd3
   } cmd_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK       = 2'd0,
      ERR_FULL     = 2'd1,
      ERR_EMPTY    = 2'd2,
      ERR_POSITION = 2'd3
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REM_LOAD,
      ST_SHIFT_CHECK,
      ST_SHIFT_WR,
      ST_TAKE,
      ST_DOWN_LOAD,
      ST_DOWN_CHECK,
      ST_DOWN_EVAL,
      ST_UP_CHECK,
      ST_UP_EVAL,
      ST_CHG_EVAL,
      ST_FINISH
   } state_type;

   // Result of one command, handed from the engine to the response register
   typedef struct packed {
      logic signed [VAL_W-1:0] taken_value;
      logic signed [VAL_W-1:0] top_value;
      logic [CNT_OUT_W-1:0]    entry_count;
      err_type                 error_code;
   } rsp_type;

endpackage : bmhq_pkg

`default_nettype wire

### rtl/bmhq_ram.sv
// ============================================================================
// bmhq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule : bmhq_ram

`default_nettype wire

### rtl/bmhq_engine.sv
// ============================================================================
// bmhq_engine
// Command sequencer: runs insert, extract, change and remove over the heap
// memory by read, compare and write-back, one heap level at a time.
// ============================================================================
`default_nettype none

module bmhq_engine #(
   parameter int CAPACITY = bmhq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bmhq_pkg::CMD_W-1:0]        req_command,
   input  wire logic [bmhq_pkg::POS_W-1:0]        req_position,
   input  wire logic signed [bmhq_pkg::VAL_W-1:0] req_priority_req,
   // finished result toward the response register
   output logic                                   fin_valid,
   input  wire logic                              fin_stall,
   output bmhq_pkg::rsp_type                      fin,
   // heap memory
   output logic                                   mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]            mem_wr_addr,
   output logic [bmhq_pkg::VAL_W-1:0]             mem_wr_data,
   output logic [$clog2(CAPACITY)-1:0]            mem_rd_addr_a,
   output logic [$clog2(CAPACITY)-1:0]            mem_rd_addr_b,
   input  wire logic [bmhq_pkg::VAL_W-1:0]        mem_rd_data_a,
   input  wire logic [bmhq_pkg::VAL_W-1:0]        mem_rd_data_b
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int XW   = CW + 1;
   localparam int CMPW = (CW > bmhq_pkg::POS_W) ? CW : bmhq_pkg::POS_W;

   bmhq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]                     idx_ff, idx_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic signed [bmhq_pkg::VAL_W-1:0] cur_ff, cur_in;
   logic signed [bmhq_pkg::VAL_W-1:0] taken_ff, taken_in;
   logic signed [bmhq_pkg::VAL_W-1:0] top_ff, top_in;
   bmhq_pkg::err_type                 err_ff, err_in;

   bmhq_pkg::cmd_type                 cmd;
   logic                              accept;
   logic                              pos_bad;
   logic                              full;
   logic                              empty;
   logic [AW-1:0]                     pos_idx;
   logic [AW-1:0]                     parent;
   logic [CW-1:0]                     new_count;
   logic [XW-1:0]                     lchild;
   logic [XW-1:0]                     rchild;
   logic                              l_ok;
   logic                              r_ok;
   logic signed [bmhq_pkg::VAL_W-1:0] rd_a;
   logic signed [bmhq_pkg::VAL_W-1:0] rd_b;
   logic signed [bmhq_pkg::VAL_W-1:0] best_val;
   logic                              pick_l;
   logic                              pick_r;
   logic                              move_down;
   logic                              move_up;
   logic [XW-1:0]                     child;
   logic signed [bmhq_pkg::VAL_W-1:0] child_val;
   logic [CMPW-1:0]                   pos_ext;

   // Decode the request and the heap geometry around the current slot
   always_comb begin
      cmd       = bmhq_pkg::cmd_type'(req_command);
      accept    = req_valid && (state_ff == bmhq_pkg::ST_IDLE);
      pos_ext   = CMPW'(req_position);
      pos_bad   = pos_ext >= CMPW'(count_ff);
      pos_idx   = pos_ext[AW-1:0];
      full      = count_ff == CW'(CAPACITY);
      empty     = count_ff == '0;
      new_count = count_ff - CW'(1);
      parent    = (idx_ff - AW'(1)) >> 1;
      lchild    = XW'({idx_ff, 1'b1});
      rchild    = lchild + XW'(1);
      l_ok      = lchild < XW'(count_ff);
      r_ok      = rchild < XW'(count_ff);
      rd_a      = $signed(mem_rd_data_a);
      rd_b      = $signed(mem_rd_data_b);
      pick_l    = rd_a > cur_ff;
      best_val  = pick_l ? rd_a : cur_ff;
      pick_r    = r_ok && (rd_b > best_val);
      move_down = pick_l || pick_r;
      child     = pick_r ? rchild : lchild;
      child_val = pick_r ? rd_b : rd_a;
      move_up   = cur_ff > rd_a;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (cmd)
                  bmhq_pkg::CMD_INSERT:
                     state_in = full ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_UP_CHECK;
                  bmhq_pkg::CMD_EXTRACT:
                     state_in = empty ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_TAKE;
                  bmhq_pkg::CMD_CHANGE:
                     state_in = pos_bad ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_CHG_EVAL;
                  bmhq_pkg::CMD_REMOVE:
                     state_in = pos_bad ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_REM_LOAD;
               endcase
            end
         end
         bmhq_pkg::ST_REM_LOAD:    state_in = bmhq_pkg::ST_SHIFT_CHECK;
         bmhq_pkg::ST_SHIFT_CHECK:
            state_in = (idx_ff == '0) ? bmhq_pkg::ST_TAKE : bmhq_pkg::ST_SHIFT_WR;
         bmhq_pkg::ST_SHIFT_WR:    state_in = bmhq_pkg::ST_SHIFT_CHECK;
         bmhq_pkg::ST_TAKE:
            state_in = (new_count == '0) ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_DOWN_LOAD;
         bmhq_pkg::ST_DOWN_LOAD:   state_in = bmhq_pkg::ST_DOWN_CHECK;
         bmhq_pkg::ST_DOWN_CHECK:
            state_in = l_ok ? bmhq_pkg::ST_DOWN_EVAL : bmhq_pkg::ST_FINISH;
         bmhq_pkg::ST_DOWN_EVAL:
            state_in = move_down ? bmhq_pkg::ST_DOWN_CHECK : bmhq_pkg::ST_FINISH;
         bmhq_pkg::ST_UP_CHECK:
            state_in = (idx_ff == '0) ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_UP_EVAL;
         bmhq_pkg::ST_UP_EVAL:
            state_in = move_up ? bmhq_pkg::ST_UP_CHECK : bmhq_pkg::ST_FINISH;
         bmhq_pkg::ST_CHG_EVAL:
            state_in = move_up ? bmhq_pkg::ST_UP_CHECK : bmhq_pkg::ST_DOWN_CHECK;
         bmhq_pkg::ST_FINISH:
            state_in = fin_stall ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_IDLE;
         default:                  state_in = bmhq_pkg::ST_IDLE;
      endcase
   end

   // Memory accesses and handshake outputs per state
   always_comb begin
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = cur_ff;
      mem_rd_addr_a = '0;
      mem_rd_addr_b = '0;
      fin_valid     = 1'b0;
      req_stall     = state_ff != bmhq_pkg::ST_IDLE;
      unique case (state_ff)
         bmhq_pkg::ST_IDLE:        mem_rd_addr_a = pos_idx;
         bmhq_pkg::ST_SHIFT_CHECK: mem_rd_addr_a = parent;
         bmhq_pkg::ST_SHIFT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data_a;
         end
         bmhq_pkg::ST_TAKE:        mem_rd_addr_a = new_count[AW-1:0];
         bmhq_pkg::ST_DOWN_CHECK: begin
            if (l_ok) begin
               mem_rd_addr_a = lchild[AW-1:0];
               mem_rd_addr_b = rchild[AW-1:0];
            end else begin
               mem_wr_en = 1'b1;
            end
         end
         bmhq_pkg::ST_DOWN_EVAL: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = move_down ? child_val : cur_ff;
         end
         bmhq_pkg::ST_UP_CHECK: begin
            if (idx_ff == '0) begin
               mem_wr_en = 1'b1;
            end else begin
               mem_rd_addr_a = parent;
            end
         end
         bmhq_pkg::ST_UP_EVAL: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = move_up ? rd_a : cur_ff;
         end
         bmhq_pkg::ST_FINISH:      fin_valid = 1'b1;
         default: begin
         end
      endcase
   end

   // Datapath register updates
   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      taken_in = taken_ff;
      err_in   = err_ff;
      top_in   = top_ff;
      unique case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            if (accept) begin
               cur_in   = req_priority_req;
               taken_in = '0;
               err_in   = bmhq_pkg::ERR_OK;
               idx_in   = pos_idx;
               unique case (cmd)
                  bmhq_pkg::CMD_INSERT: begin
                     if (full) begin
                        err_in = bmhq_pkg::ERR_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        idx_in   = count_ff[AW-1:0];
                     end
                  end
                  bmhq_pkg::CMD_EXTRACT: begin
                     if (empty) begin
                        err_in = bmhq_pkg::ERR_EMPTY;
                     end else begin
                        taken_in = top_ff;
                     end
                  end
                  bmhq_pkg::CMD_CHANGE,
                  bmhq_pkg::CMD_REMOVE: begin
                     if (pos_bad) begin
                        err_in = bmhq_pkg::ERR_POSITION;
                     end
                  end
               endcase
            end
         end
         bmhq_pkg::ST_REM_LOAD:  taken_in = rd_a;
         bmhq_pkg::ST_SHIFT_WR:  idx_in   = parent;
         bmhq_pkg::ST_TAKE: begin
            count_in = new_count;
            idx_in   = '0;
         end
         bmhq_pkg::ST_DOWN_LOAD: cur_in = rd_a;
         bmhq_pkg::ST_DOWN_EVAL: begin
            if (move_down) begin
               idx_in = child[AW-1:0];
            end
         end
         bmhq_pkg::ST_UP_EVAL: begin
            if (move_up) begin
               idx_in = parent;
            end
         end
         default: begin
         end
      endcase
      // Mirror slot zero so the maximum is always at hand
      if (mem_wr_en && (mem_wr_addr == '0)) begin
         top_in = $signed(mem_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      cur_ff   <= cur_in;
      taken_ff <= taken_in;
      err_ff   <= err_in;
      top_ff   <= top_in;
   end

   // Assemble the finished result
   always_comb begin
      fin.taken_value = taken_ff;
      fin.top_value   = empty ? '0 : top_ff;
      fin.entry_count = bmhq_pkg::CNT_OUT_W'(count_ff);
      fin.error_code  = err_ff;
   end

endmodule : bmhq_engine

`default_nettype wire

### rtl/binary_max_heap_queue.sv
// ============================================================================
// binary_max_heap_queue
// Max-heap priority queue of signed 32-bit priorities held in one RAM.
// ============================================================================
// Each request transaction is one command (insert, extract maximum, change
// priority at a slot, remove at a slot) and yields exactly one response
// transaction with the value taken out, the new maximum, the entry count and
// an error code; a failing command leaves the heap unchanged. Commands are
// processed one at a time. The heap RAM has a registered read, so every heap
// level walked takes a read step, then a compare and write-back step. A
// remove first walks up to the root, moving each ancestor down one slot,
// then sifts down as an extract does. The response register lets the next
// request be taken while a response still waits. No clearing pass runs
// after reset: only values from slots below the count are ever used.
`default_nettype none

module binary_max_heap_queue #(
   parameter int CAPACITY = bmhq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bmhq_pkg::CMD_W-1:0]        req_command,
   input  wire logic [bmhq_pkg::POS_W-1:0]        req_position,
   input  wire logic signed [bmhq_pkg::VAL_W-1:0] req_priority_req,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [bmhq_pkg::VAL_W-1:0]      rsp_taken_value,
   output logic signed [bmhq_pkg::VAL_W-1:0]      rsp_top_value,
   output logic [bmhq_pkg::CNT_OUT_W-1:0]         rsp_entry_count,
   output logic [bmhq_pkg::ERR_W-1:0]             rsp_error_code
);

   localparam int AW = $clog2(CAPACITY);

   logic                         fin_valid;
   logic                         fin_stall;
   bmhq_pkg::rsp_type            fin;
   logic                         mem_wr_en;
   logic [AW-1:0]                mem_wr_addr;
   logic [bmhq_pkg::VAL_W-1:0]   mem_wr_data;
   logic [AW-1:0]                mem_rd_addr_a;
   logic [AW-1:0]                mem_rd_addr_b;
   logic [bmhq_pkg::VAL_W-1:0]   mem_rd_data_a;
   logic [bmhq_pkg::VAL_W-1:0]   mem_rd_data_b;

   logic                         rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::rsp_type            rsp_ff, rsp_in;

   bmhq_ram #(
      .WIDTH (bmhq_pkg::VAL_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   bmhq_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_position     (req_position),
      .req_priority_req (req_priority_req),
      .fin_valid        (fin_valid),
      .fin_stall        (fin_stall),
      .fin              (fin),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr_a    (mem_rd_addr_a),
      .mem_rd_addr_b    (mem_rd_addr_b),
      .mem_rd_data_a    (mem_rd_data_a),
      .mem_rd_data_b    (mem_rd_data_b)
   );

   // Hold a finished result until the response transaction completes
   always_comb begin
      fin_stall    = rsp_valid_ff && rsp_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fin_valid && !fin_stall) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fin;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_taken_value = rsp_ff.taken_value;
   assign rsp_top_value   = rsp_ff.top_value;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_error_code  = rsp_ff.error_code;

   // Taking a request makes the engine busy, so req_stall rises
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine ready right after taking a request");

   // Failed commands never report a taken value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code != bmhq_pkg::ERR_OK)) |-> (rsp_taken_value == '0))
      else $error("failed command reports a taken value");

   // Full is only flagged at capacity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code == bmhq_pkg::ERR_FULL))
         |-> (rsp_entry_count == bmhq_pkg::CNT_OUT_W'(CAPACITY)))
      else $error("full flagged below capacity");

   // Empty is only flagged with no entries, and then the maximum reads zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code == bmhq_pkg::ERR_EMPTY))
         |-> ((rsp_entry_count == '0) && (rsp_top_value == '0)))
      else $error("empty flagged with entries present");

endmodule : binary_max_heap_queue

`default_nettype wire
